// File: rtl/tpsc_pkg.sv
// Shared widths, constants and pipeline word types of the two-point calibration block.
package tpsc_pkg;

  // Magnitude widths of the dividends and the divisor.
  localparam int unsigned NUM_W = 37;
  localparam int unsigned DEN_W = 16;

  localparam logic signed [13:0] SLOPE_SCALE = 14'sd8000;
  localparam logic signed [10:0] BIAS_SCALE  = 11'sd1000;

  // Billionths per fraction step: 10^9 / 16 and 10^9 / 64.
  localparam logic [26:0] NANO_STEP_HUM  = 27'd62500000;
  localparam logic [26:0] NANO_STEP_TEMP = 27'd15625000;

  localparam logic [31:0] OFFSET_POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] OFFSET_NEG_MAX = 32'h8000_0000;
  localparam logic [NUM_W-1:0] SAT_LIMIT = NUM_W'(37'h0_1000_0000);

  typedef struct packed {
    logic kind;
    logic zero;
    logic gain_neg;
    logic bias_neg;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] work_g;
    logic [NUM_W-1:0] work_b;
    logic [DEN_W-1:0] rem_g;
    logic [DEN_W-1:0] rem_b;
    logic [DEN_W-1:0] den;
    side_t            side;
  } div_word_t;

endpackage

// File: rtl/tpsc_div.sv
// Pipelined restoring divider: two magnitudes over one divisor, one quotient bit per stage.
module tpsc_div import tpsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  div_word_t word_i,
  output logic      valid_o,
  output div_word_t word_o
);

  function automatic div_word_t div_step(div_word_t w);
    logic [DEN_W:0] rg;
    logic [DEN_W:0] rb;
    div_word_t      r;
    r  = w;
    rg = {w.rem_g, w.work_g[NUM_W-1]};
    rb = {w.rem_b, w.work_b[NUM_W-1]};
    if (rg >= {1'b0, w.den}) begin
      rg       = rg - {1'b0, w.den};
      r.work_g = {w.work_g[NUM_W-2:0], 1'b1};
    end else begin
      r.work_g = {w.work_g[NUM_W-2:0], 1'b0};
    end
    if (rb >= {1'b0, w.den}) begin
      rb       = rb - {1'b0, w.den};
      r.work_b = {w.work_b[NUM_W-2:0], 1'b1};
    end else begin
      r.work_b = {w.work_b[NUM_W-2:0], 1'b0};
    end
    r.rem_g = rg[DEN_W-1:0];
    r.rem_b = rb[DEN_W-1:0];
    return r;
  endfunction

  logic [NUM_W-1:0] valid_q;
  div_word_t        word_q [NUM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NUM_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    word_q[0] <= div_step(word_i);
    for (int i = 1; i < NUM_W; i++) begin
      word_q[i] <= div_step(word_q[i-1]);
    end
  end

  assign valid_o = valid_q[NUM_W-1];
  assign word_o  = word_q[NUM_W-1];

endmodule

// File: rtl/two_point_sensor_calibration.sv
// Top level of the two-point sensor calibration pipeline.
//
// A calibration word enters when start is high; busy is always low, so
// a new word may enter in every cycle. Each word yields exactly one result,
// shown on the result ports for one cycle with valid_o high.
//
// Stages 1 to 3 form the products and magnitudes, the restoring divider
// then yields one quotient bit per stage (its depth set by the 37-bit bias
// dividend), and stages 4 and 5 clamp the bias, apply signs and split both
// values into whole and billionth parts. Throughput is one word per cycle.
//
// Reset clears only the valid bits of the stages, so no result comes out
// until a word has travelled the whole pipeline. The receiver cannot stall;
// results are never held back.
module two_point_sensor_calibration import tpsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        sensor_kind_i,
  input  logic [7:0]  ref_low_first_i,
  input  logic [7:0]  ref_low_second_i,
  input  logic [7:0]  ref_high_bits_i,
  input  logic signed [15:0] raw_point_first_i,
  input  logic signed [15:0] raw_point_second_i,
  output logic        valid_o,
  output logic signed [23:0] gain_o,
  output logic signed [31:0] offset_o,
  output logic signed [19:0] gain_whole_o,
  output logic [29:0] gain_nano_o,
  output logic signed [27:0] offset_whole_o,
  output logic [29:0] offset_nano_o,
  output logic        zero_span_error_o,
  output logic        offset_saturated_o
);

  assign busy = 1'b0;

  // Stage 1: reference values, products and span.
  logic [9:0]         y0, y1;
  logic signed [10:0] dy;
  logic               s1_valid_q;
  logic               s1_kind_q;
  logic signed [24:0] s1_gnum_q, s1_gnum_d;
  logic signed [26:0] s1_pa_q, s1_pa_d, s1_pb_q, s1_pb_d;
  logic signed [16:0] s1_dx_q, s1_dx_d;

  always_comb begin
    if (sensor_kind_i) begin
      y0 = {ref_high_bits_i[1:0], ref_low_first_i};
      y1 = {ref_high_bits_i[3:2], ref_low_second_i};
    end else begin
      y0 = {2'b00, ref_low_first_i};
      y1 = {2'b00, ref_low_second_i};
    end
    dy        = $signed({1'b0, y1}) - $signed({1'b0, y0});
    s1_gnum_d = 25'(dy * SLOPE_SCALE);
    s1_pa_d   = 27'(raw_point_second_i * $signed({1'b0, y0}));
    s1_pb_d   = 27'(raw_point_first_i * $signed({1'b0, y1}));
    s1_dx_d   = $signed({raw_point_second_i[15], raw_point_second_i})
              - $signed({raw_point_first_i[15], raw_point_first_i});
  end

  // Stage 2: bias numerator scaled by 1000.
  logic               s2_valid_q;
  logic               s2_kind_q;
  logic signed [24:0] s2_gnum_q;
  logic signed [16:0] s2_dx_q;
  logic signed [27:0] bdiff;
  logic signed [37:0] s2_bnum_q, s2_bnum_d;

  always_comb begin
    bdiff     = $signed({s1_pa_q[26], s1_pa_q}) - $signed({s1_pb_q[26], s1_pb_q});
    s2_bnum_d = 38'(bdiff * BIAS_SCALE);
  end

  // Stage 3: magnitudes and signs for the divider.
  logic               s3_valid_q;
  div_word_t          s3_word_q, s3_word_d;
  logic [24:0]        gabs;
  logic [37:0]        babs;
  logic [16:0]        dabs;

  always_comb begin
    gabs = s2_gnum_q[24] ? 25'(-s2_gnum_q) : 25'(s2_gnum_q);
    babs = s2_bnum_q[37] ? 38'(-s2_bnum_q) : 38'(s2_bnum_q);
    dabs = s2_dx_q[16] ? 17'(-s2_dx_q) : 17'(s2_dx_q);
    s3_word_d.work_g        = NUM_W'(gabs);
    s3_word_d.work_b        = babs[NUM_W-1:0];
    s3_word_d.rem_g         = '0;
    s3_word_d.rem_b         = '0;
    s3_word_d.den           = dabs[DEN_W-1:0];
    s3_word_d.side.kind     = s2_kind_q;
    s3_word_d.side.zero     = (s2_dx_q == '0);
    s3_word_d.side.gain_neg = s2_gnum_q[24] ^ s2_dx_q[16];
    s3_word_d.side.bias_neg = s2_bnum_q[37] ^ s2_dx_q[16];
  end

  logic      dv_valid;
  div_word_t dv_word;

  tpsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid_q),
    .word_i  (s3_word_q),
    .valid_o (dv_valid),
    .word_o  (dv_word)
  );

  // Stage 4: clamp the bias and keep magnitudes with their signs.
  logic        s4_valid_q;
  logic        s4_kind_q;
  logic        s4_zero_q;
  logic        s4_gneg_q, s4_gneg_d;
  logic        s4_bneg_q, s4_bneg_d;
  logic        s4_sat_q, s4_sat_d;
  logic [23:0] s4_gmag_q, s4_gmag_d;
  logic [31:0] s4_bmag_q, s4_bmag_d;

  always_comb begin
    s4_gneg_d = dv_word.side.gain_neg;
    s4_bneg_d = dv_word.side.bias_neg;
    s4_gmag_d = dv_word.work_g[23:0];
    if (dv_word.side.bias_neg) begin
      s4_sat_d = dv_word.work_b > SAT_LIMIT;
    end else begin
      s4_sat_d = dv_word.work_b >= SAT_LIMIT;
    end
    if (s4_sat_d) begin
      s4_bmag_d = dv_word.side.bias_neg ? OFFSET_NEG_MAX : OFFSET_POS_MAX;
    end else begin
      s4_bmag_d = {dv_word.work_b[28:0], 3'b000};
    end
    // A zero span gives an all-zero result apart from the error flag.
    if (dv_word.side.zero) begin
      s4_gneg_d = 1'b0;
      s4_bneg_d = 1'b0;
      s4_sat_d  = 1'b0;
      s4_gmag_d = '0;
      s4_bmag_d = '0;
    end
  end

  // Stage 5: signed values and the whole / billionth split.
  logic [23:0] gshift;
  logic [31:0] bshift;
  logic [29:0] gnano_d, bnano_d;

  always_comb begin
    if (s4_kind_q) begin
      gshift  = s4_gmag_q >> 6;
      bshift  = s4_bmag_q >> 6;
      gnano_d = 30'(s4_gmag_q[5:0] * NANO_STEP_TEMP);
      bnano_d = 30'(s4_bmag_q[5:0] * NANO_STEP_TEMP);
    end else begin
      gshift  = s4_gmag_q >> 4;
      bshift  = s4_bmag_q >> 4;
      gnano_d = 30'(s4_gmag_q[3:0] * NANO_STEP_HUM);
      bnano_d = 30'(s4_bmag_q[3:0] * NANO_STEP_HUM);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else begin
      s1_valid_q <= start;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= dv_valid;
      valid_o    <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q <= sensor_kind_i;
    s1_gnum_q <= s1_gnum_d;
    s1_pa_q   <= s1_pa_d;
    s1_pb_q   <= s1_pb_d;
    s1_dx_q   <= s1_dx_d;

    s2_kind_q <= s1_kind_q;
    s2_gnum_q <= s1_gnum_q;
    s2_dx_q   <= s1_dx_q;
    s2_bnum_q <= s2_bnum_d;

    s3_word_q <= s3_word_d;

    s4_kind_q <= dv_word.side.kind;
    s4_zero_q <= dv_word.side.zero;
    s4_gneg_q <= s4_gneg_d;
    s4_bneg_q <= s4_bneg_d;
    s4_sat_q  <= s4_sat_d;
    s4_gmag_q <= s4_gmag_d;
    s4_bmag_q <= s4_bmag_d;

    gain_o             <= s4_gneg_q ? -s4_gmag_q : s4_gmag_q;
    offset_o           <= s4_bneg_q ? -s4_bmag_q : s4_bmag_q;
    gain_whole_o       <= s4_gneg_q ? 20'(-gshift) : gshift[19:0];
    offset_whole_o     <= s4_bneg_q ? 28'(-bshift) : bshift[27:0];
    gain_nano_o        <= gnano_d;
    offset_nano_o      <= bnano_d;
    zero_span_error_o  <= s4_zero_q;
    offset_saturated_o <= s4_sat_q;
  end

endmodule

// File: tb/two_point_sensor_calibration_test.sv
// Self-checking testbench for the two-point sensor calibration block.
module two_point_sensor_calibration_test;
  import tpsc_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1450;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam longint      BILLION      = 64'sd1000000000;

  typedef struct packed {
    logic              kind;
    logic [7:0]        lo_first;
    logic [7:0]        lo_second;
    logic [7:0]        high_bits;
    logic signed [15:0] x_first;
    logic signed [15:0] x_second;
  } calib_word_t;

  typedef struct packed {
    logic signed [23:0] gain;
    logic signed [31:0] offset;
    logic signed [19:0] gain_whole;
    logic [29:0]        gain_nano;
    logic signed [27:0] offset_whole;
    logic [29:0]        offset_nano;
    logic               zero_span;
    logic               saturated;
  } calib_line_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  logic sensor_kind_i = 1'b0;
  logic [7:0] ref_low_first_i = '0;
  logic [7:0] ref_low_second_i = '0;
  logic [7:0] ref_high_bits_i = '0;
  logic signed [15:0] raw_point_first_i = '0;
  logic signed [15:0] raw_point_second_i = '0;
  logic valid_o;
  logic signed [23:0] gain_o;
  logic signed [31:0] offset_o;
  logic signed [19:0] gain_whole_o;
  logic [29:0] gain_nano_o;
  logic signed [27:0] offset_whole_o;
  logic [29:0] offset_nano_o;
  logic zero_span_error_o;
  logic offset_saturated_o;

  calib_word_t pending_words[$];
  calib_line_t expected_lines[$];
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned lines_checked = 0;
  int unsigned zero_spans = 0;
  int unsigned saturations = 0;
  int unsigned cycle_count = 0;

  two_point_sensor_calibration u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .sensor_kind_i(sensor_kind_i), .ref_low_first_i(ref_low_first_i),
    .ref_low_second_i(ref_low_second_i), .ref_high_bits_i(ref_high_bits_i),
    .raw_point_first_i(raw_point_first_i), .raw_point_second_i(raw_point_second_i),
    .valid_o(valid_o), .gain_o(gain_o), .offset_o(offset_o),
    .gain_whole_o(gain_whole_o), .gain_nano_o(gain_nano_o),
    .offset_whole_o(offset_whole_o), .offset_nano_o(offset_nano_o),
    .zero_span_error_o(zero_span_error_o), .offset_saturated_o(offset_saturated_o)
  );

  always #2 clk_i = ~clk_i;

  // Splits a fixed-point value into its whole part and absolute billionths.
  function automatic void split_fixed(input longint value, input longint frac_div,
                                      output longint whole, output longint nano);
    longint scaled;
    scaled = (value * BILLION) / frac_div;
    whole  = scaled / BILLION;
    nano   = scaled % BILLION;
    if (nano < 0) nano = -nano;
  endfunction

  function automatic calib_line_t fit_line(input calib_word_t w);
    calib_line_t line;
    longint y0, y1, x0, x1, dx, slope, bias, frac_div, gw, gn, ow, on;
    line = '0;
    x0 = w.x_first;
    x1 = w.x_second;
    if (w.kind) begin
      y0 = {w.high_bits[1:0], w.lo_first};
      y1 = {w.high_bits[3:2], w.lo_second};
      frac_div = 64;
    end else begin
      y0 = w.lo_first;
      y1 = w.lo_second;
      frac_div = 16;
    end
    dx = x1 - x0;
    if (dx == 0) begin
      line.zero_span = 1'b1;
      return line;
    end
    slope = ((y1 - y0) * 8000) / dx;
    bias  = (((x1 * y0 - x0 * y1) * 1000) / dx) * 8;
    if (bias > 64'sd2147483647) begin
      bias = 64'sd2147483647;
      line.saturated = 1'b1;
    end else if (bias < -64'sd2147483648) begin
      bias = -64'sd2147483648;
      line.saturated = 1'b1;
    end
    split_fixed(slope, frac_div, gw, gn);
    split_fixed(bias, frac_div, ow, on);
    line.gain         = slope[23:0];
    line.offset       = bias[31:0];
    line.gain_whole   = gw[19:0];
    line.gain_nano    = gn[29:0];
    line.offset_whole = ow[27:0];
    line.offset_nano  = on[29:0];
    return line;
  endfunction

  function automatic calib_word_t make_word(input bit kind, input int lo0, input int lo1,
                                            input int hb, input int x0, input int x1);
    calib_word_t w;
    w.kind = kind;
    w.lo_first = lo0[7:0];
    w.lo_second = lo1[7:0];
    w.high_bits = hb[7:0];
    w.x_first = x0[15:0];
    w.x_second = x1[15:0];
    return w;
  endfunction

  // Driver: the word on the ports is taken at an edge where start is high and busy low.
  always @(posedge clk_i) begin
    calib_word_t w;
    bit idle;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (start && !busy) begin
        w = {sensor_kind_i, ref_low_first_i, ref_low_second_i, ref_high_bits_i,
             raw_point_first_i, raw_point_second_i};
        expected_lines.push_back(fit_line(w));
        words_sent++;
      end
      if (start && busy) begin
        // Hold the current word until it is taken.
      end else begin
        idle = (words_sent < 500 || words_sent > 800) && ($urandom_range(99) < 27);
        if (pending_words.size() == 0 || idle) begin
          start <= 1'b0;
        end else begin
          w = pending_words.pop_front();
          start <= 1'b1;
          sensor_kind_i <= w.kind;
          ref_low_first_i <= w.lo_first;
          ref_low_second_i <= w.lo_second;
          ref_high_bits_i <= w.high_bits;
          raw_point_first_i <= w.x_first;
          raw_point_second_i <= w.x_second;
        end
      end
    end
  end

  // Monitor: each strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    calib_line_t exp_line;
    if (rst_ni && valid_o) begin
      if (expected_lines.size() == 0) begin
        $error("unexpected result word");
        error_count++;
      end else begin
        exp_line = expected_lines.pop_front();
        lines_checked++;
        if (exp_line.zero_span) zero_spans++;
        if (exp_line.saturated) saturations++;
        if (gain_o !== exp_line.gain) begin
          $error("gain: expected %0d, got %0d", exp_line.gain, gain_o);
          error_count++;
        end
        if (offset_o !== exp_line.offset) begin
          $error("offset: expected %0d, got %0d", exp_line.offset, offset_o);
          error_count++;
        end
        if (gain_whole_o !== exp_line.gain_whole) begin
          $error("gain_whole: expected %0d, got %0d", exp_line.gain_whole, gain_whole_o);
          error_count++;
        end
        if (gain_nano_o !== exp_line.gain_nano) begin
          $error("gain_nano: expected %0d, got %0d", exp_line.gain_nano, gain_nano_o);
          error_count++;
        end
        if (offset_whole_o !== exp_line.offset_whole) begin
          $error("offset_whole: expected %0d, got %0d", exp_line.offset_whole,
                 offset_whole_o);
          error_count++;
        end
        if (offset_nano_o !== exp_line.offset_nano) begin
          $error("offset_nano: expected %0d, got %0d", exp_line.offset_nano, offset_nano_o);
          error_count++;
        end
        if (zero_span_error_o !== exp_line.zero_span) begin
          $error("zero_span_error: expected %0d, got %0d", exp_line.zero_span,
                 zero_span_error_o);
          error_count++;
        end
        if (offset_saturated_o !== exp_line.saturated) begin
          $error("offset_saturated: expected %0d, got %0d", exp_line.saturated,
                 offset_saturated_o);
          error_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int x0, x1, pick;
    // Directed words: field extremes, equal points and clamping both ways.
    pending_words.push_back(make_word(0, 0, 255, 0, -32768, 32767));
    pending_words.push_back(make_word(1, 255, 0, 8'hff, 32767, -32768));
    pending_words.push_back(make_word(0, 10, 200, 0, 5, 5));
    pending_words.push_back(make_word(1, 255, 255, 8'hff, -32768, -32768));
    pending_words.push_back(make_word(1, 255, 0, 8'h03, 32766, 32767));
    pending_words.push_back(make_word(1, 0, 255, 8'h0c, 32766, 32767));
    pending_words.push_back(make_word(1, 0, 255, 8'h0c, -32768, -32767));
    pending_words.push_back(make_word(0, 255, 0, 8'hf0, 32767, 32766));
    pending_words.push_back(make_word(0, 0, 0, 8'hff, 100, 200));
    pending_words.push_back(make_word(1, 0, 0, 8'hf0, 1, -1));
    pending_words.push_back(make_word(1, 128, 64, 8'h09, -1000, 3000));
    pending_words.push_back(make_word(0, 77, 33, 8'h5a, 0, 1));
    pending_words.push_back(make_word(1, 1, 2, 8'h06, 0, -1));
    // Random words: wide spans, narrow spans that push the bias to its limits,
    // and occasional equal points.
    repeat (RANDOM_WORDS) begin
      x0 = $urandom_range(65535) - 32768;
      pick = $urandom_range(9);
      if (pick < 5) x1 = $urandom_range(65535) - 32768;
      else if (pick < 9) x1 = x0 + $urandom_range(64) - 32;
      else x1 = x0;
      if (x1 > 32767 || x1 < -32768) x1 = x0 - 1;
      pending_words.push_back(make_word($urandom_range(1), $urandom_range(255),
                              $urandom_range(255), $urandom_range(255), x0, x1));
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_words.size() == 0 && !start && expected_lines.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d calibration words over both sensor kinds, %0d with equal points",
             lines_checked, zero_spans);
    $display("and %0d with a clamped offset.", saturations);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
